// ----- sv/ocp_pkg.sv -----
// Shared types and constants of the omnidirectional camera projection block.
// Used by every other file of the block; depends on nothing.
package ocp_pkg;

  localparam int DATA_W        = 32;
  localparam int XI_W          = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IDX_W         = 3;
  localparam int ROOT_W        = 32;
  localparam int SQ_W          = 2 * ROOT_W;
  localparam int NUM_W         = 63;
  // Quotient bits that are resolved exactly; anything larger saturates anyway.
  localparam int QUO_W         = 34;

  // Register reset values in whole units, scaled by the fraction bits at the top.
  localparam int FOCAL_RST_INT = 500;
  localparam int CX_RST_INT    = 320;
  localparam int CY_RST_INT    = 240;
  localparam int XI_RST_INT    = 1;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_MIRROR_XI = 3'd4
  } cfg_reg_t;

  // Rounded quotient of one divider lane; big marks a quotient beyond QUO_W bits.
  typedef struct packed {
    logic           big;
    logic [QUO_W:0] quo;
  } quot_t;

endpackage

// ----- sv/ocp_if.sv -----
// Stream channels of the projection block: camera points in, pixels out.
// Depends on ocp_pkg for the field widths.
interface ocp_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [ocp_pkg::DATA_W-1:0] point_x;
  logic signed [ocp_pkg::DATA_W-1:0] point_y;
  logic signed [ocp_pkg::DATA_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ocp_pixel_if;
  logic                              valid;
  logic                              ready;
  logic signed [ocp_pkg::DATA_W-1:0] pixel_u;
  logic signed [ocp_pkg::DATA_W-1:0] pixel_v;
  logic                              invalid;
  logic                              saturated;

  modport source (output valid, pixel_u, pixel_v, invalid, saturated, input ready);
  modport sink (input valid, pixel_u, pixel_v, invalid, saturated, output ready);
endinterface

// ----- sv/ocp_isqrt.sv -----
// Pipelined integer square root, one root bit resolved per register stage.
// Carries a sideband word alongside; depends on ocp_pkg.
module ocp_isqrt #(
  parameter int SB_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ocp_pkg::SQ_W-1:0]    radicand,
  input  logic [SB_W-1:0]             sb_in,
  output logic                        out_valid,
  output logic [ocp_pkg::ROOT_W-1:0]  root,
  output logic [SB_W-1:0]             sb_out
);

  localparam int N     = ocp_pkg::ROOT_W;
  localparam int REM_W = N + 3;

  logic             vld [1:N];
  logic [REM_W-1:0] rem [1:N];
  logic [N-1:0]     rt  [1:N];
  logic [2*N-1:0]   rad [1:N];
  logic [SB_W-1:0]  sb  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             prev_vld;
    logic [REM_W-1:0] prev_rem;
    logic [N-1:0]     prev_rt;
    logic [2*N-1:0]   prev_rad;
    logic [SB_W-1:0]  prev_sb;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign prev_vld = in_valid;
      assign prev_rem = '0;
      assign prev_rt  = '0;
      assign prev_rad = radicand;
      assign prev_sb  = sb_in;
    end else begin : g_next
      assign prev_vld = vld[k];
      assign prev_rem = rem[k];
      assign prev_rt  = rt[k];
      assign prev_rad = rad[k];
      assign prev_sb  = sb[k];
    end

    // The remainder never exceeds twice the partial root, so its top bits are free.
    assign rem_sh = {prev_rem[REM_W-3:0], prev_rad[2*N-1 -: 2]};
    assign trial  = {1'b0, prev_rt, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? (rem_sh - trial) : rem_sh;
        rt[k+1]  <= {prev_rt[N-2:0], take};
        rad[k+1] <= {prev_rad[2*N-3:0], 2'b00};
        sb[k+1]  <= prev_sb;
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N];
  assign sb_out    = sb[N];

endmodule

// ----- sv/ocp_div.sv -----
// Pipelined restoring divider with round half away from zero, one quotient
// bit per stage, plus an overflow check. Depends on ocp_pkg.
module ocp_div #(
  parameter int DEN_W = 35,
  parameter int SB_W  = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ocp_pkg::NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]           den,
  input  logic [SB_W-1:0]            sb_in,
  output logic                       out_valid,
  output ocp_pkg::quot_t             res,
  output logic [SB_W-1:0]            sb_out
);

  localparam int QW   = ocp_pkg::QUO_W;
  localparam int HI_W = ocp_pkg::NUM_W - QW;
  localparam int CW   = (DEN_W > HI_W) ? DEN_W : HI_W;

  // Front stage: high numerator bits seed the remainder. If they already reach
  // the divisor, the quotient needs more than QW bits.
  logic             p_vld;
  logic             p_big;
  logic [DEN_W-1:0] p_rem;
  logic [QW-1:0]    p_lo;
  logic [DEN_W-1:0] p_den;
  logic [SB_W-1:0]  p_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_big <= CW'(num[ocp_pkg::NUM_W-1:QW]) >= CW'(den);
      p_rem <= DEN_W'(num[ocp_pkg::NUM_W-1:QW]);
      p_lo  <= num[QW-1:0];
      p_den <= den;
      p_sb  <= sb_in;
    end
  end

  logic             vld [1:QW];
  logic             big [1:QW];
  logic [DEN_W-1:0] rem [1:QW];
  logic [QW-1:0]    lo  [1:QW];
  logic [QW-1:0]    q   [1:QW];
  logic [DEN_W-1:0] dv  [1:QW];
  logic [SB_W-1:0]  sb  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             prev_vld;
    logic             prev_big;
    logic [DEN_W-1:0] prev_rem;
    logic [QW-1:0]    prev_lo;
    logic [QW-1:0]    prev_q;
    logic [DEN_W-1:0] prev_dv;
    logic [SB_W-1:0]  prev_sb;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign prev_vld = p_vld;
      assign prev_big = p_big;
      assign prev_rem = p_rem;
      assign prev_lo  = p_lo;
      assign prev_q   = '0;
      assign prev_dv  = p_den;
      assign prev_sb  = p_sb;
    end else begin : g_next
      assign prev_vld = vld[k];
      assign prev_big = big[k];
      assign prev_rem = rem[k];
      assign prev_lo  = lo[k];
      assign prev_q   = q[k];
      assign prev_dv  = dv[k];
      assign prev_sb  = sb[k];
    end

    assign r2   = {prev_rem, prev_lo[QW-1]};
    assign diff = r2 - {1'b0, prev_dv};
    assign take = r2 >= {1'b0, prev_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        lo[k+1]  <= {prev_lo[QW-2:0], 1'b0};
        q[k+1]   <= {prev_q[QW-2:0], take};
        big[k+1] <= prev_big;
        dv[k+1]  <= prev_dv;
        sb[k+1]  <= prev_sb;
      end
    end
  end

  // Round up when the remainder is at least half the divisor.
  logic round_up;
  assign round_up = {rem[QW], 1'b0} >= {1'b0, dv[QW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.big <= big[QW];
      res.quo <= {1'b0, q[QW]} + (QW+1)'(round_up);
      sb_out  <= sb[QW];
    end
  end

endmodule

// ----- sv/omni_camera_projection.sv -----
// Channel  | Dir | Payload                                   | Handshake
// point    | in  | point_x, point_y, point_z (Q16.16)        | valid/ready
// pixel    | out | pixel_u, pixel_v (Q16.16), invalid, sat.  | valid/ready
// cfg      | in  | cfg_index, cfg_data                       | cfg_wr_en only
//
// One point is accepted per cycle while point.ready is high; a pixel request passes through
// the 32 square root stages, the 36 divider stages and eight stages around them.
// rst is synchronous and clears all valid bits and loads the register defaults.
// A stall on the pixel side fills a one-entry skid buffer; point.ready drops
// while it is full, and the whole pipeline holds without losing a request.
// Top level of the omnidirectional projection; uses ocp_pkg, ocp_if, ocp_isqrt, ocp_div.
module omni_camera_projection #(
  parameter int FRAC_BITS = ocp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ocp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ocp_pkg::DATA_W-1:0]  cfg_data,
  ocp_point_if.sink                   point,
  ocp_pixel_if.source                 pixel
);

  localparam int DW      = ocp_pkg::DATA_W;
  localparam int XW      = ocp_pkg::XI_W;
  localparam int RW      = ocp_pkg::ROOT_W;
  localparam int NW      = ocp_pkg::NUM_W;
  localparam int QW      = ocp_pkg::QUO_W;
  localparam int PROD_W  = XW + RW;
  localparam int ETERM_W = PROD_W - FRAC_BITS;
  localparam int DEN_W   = (ETERM_W + 1 > DW) ? ETERM_W + 1 : DW;
  localparam int SDEN_W  = DEN_W + 1;
  localparam int SQ_W    = QW + 2;
  localparam int SUM_W   = SQ_W + 1;
  localparam int SB_W    = DW + 2 * NW + 2;

  localparam logic [DW-1:0] FOCAL_RST = DW'(64'(ocp_pkg::FOCAL_RST_INT) << FRAC_BITS);
  localparam logic [DW-1:0] CX_RST    = DW'(64'(ocp_pkg::CX_RST_INT) << FRAC_BITS);
  localparam logic [DW-1:0] CY_RST    = DW'(64'(ocp_pkg::CY_RST_INT) << FRAC_BITS);
  localparam logic [XW-1:0] XI_RST    = XW'(64'(ocp_pkg::XI_RST_INT) << FRAC_BITS);

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

  // Configuration registers.
  logic [DW-1:0]        focal_x;
  logic [DW-1:0]        focal_y;
  logic signed [DW-1:0] center_x;
  logic signed [DW-1:0] center_y;
  logic [XW-1:0]        mirror_xi;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x   <= FOCAL_RST;
      focal_y   <= FOCAL_RST;
      center_x  <= CX_RST;
      center_y  <= CY_RST;
      mirror_xi <= XI_RST;
    end else if (cfg_wr_en) begin
      unique case (ocp_pkg::cfg_reg_t'(cfg_index))
        ocp_pkg::REG_FOCAL_X:   focal_x   <= cfg_data;
        ocp_pkg::REG_FOCAL_Y:   focal_y   <= cfg_data;
        ocp_pkg::REG_CENTER_X:  center_x  <= cfg_data;
        ocp_pkg::REG_CENTER_Y:  center_y  <= cfg_data;
        ocp_pkg::REG_MIRROR_XI: mirror_xi <= cfg_data[XW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance; held only while the skid buffer is occupied.
  logic en;
  logic skid_valid;
  assign en          = !skid_valid;
  assign point.ready = en;

  // Stage 1: capture the point.
  logic                 s1_valid;
  logic signed [DW-1:0] s1_x, s1_y, s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= point.point_x;
      s1_y <= point.point_y;
      s1_z <= point.point_z;
    end
  end

  // Stage 2: magnitudes, squares and the two numerators.
  logic [DW-1:0]        ax, ay, az;
  logic                 s2_valid;
  logic [2*DW-1:0]      s2_sq_x, s2_sq_y, s2_sq_z;
  logic [NW-1:0]        s2_num_x, s2_num_y;
  logic signed [DW-1:0] s2_z;
  logic                 s2_neg_x, s2_neg_y;

  assign ax = s1_x[DW-1] ? (DW'(0) - s1_x) : s1_x;
  assign ay = s1_y[DW-1] ? (DW'(0) - s1_y) : s1_y;
  assign az = s1_z[DW-1] ? (DW'(0) - s1_z) : s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq_x  <= (2*DW)'(ax) * (2*DW)'(ax);
      s2_sq_y  <= (2*DW)'(ay) * (2*DW)'(ay);
      s2_sq_z  <= (2*DW)'(az) * (2*DW)'(az);
      s2_num_x <= NW'((2*DW)'(focal_x) * (2*DW)'(ax));
      s2_num_y <= NW'((2*DW)'(focal_y) * (2*DW)'(ay));
      s2_z     <= s1_z;
      s2_neg_x <= s1_x[DW-1];
      s2_neg_y <= s1_y[DW-1];
    end
  end

  // Stage 3: sum of squares.
  logic                 s3_valid;
  logic [2*DW-1:0]      s3_sumsq;
  logic [SB_W-1:0]      s3_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sumsq <= s2_sq_x + s2_sq_y + s2_sq_z;
      s3_sb    <= {s2_z, s2_num_x, s2_num_y, s2_neg_x, s2_neg_y};
    end
  end

  // Radius.
  logic            rt_valid;
  logic [RW-1:0]   rt_root;
  logic [SB_W-1:0] rt_sb;

  ocp_isqrt #(
    .SB_W (SB_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .radicand  (s3_sumsq),
    .sb_in     (s3_sb),
    .out_valid (rt_valid),
    .root      (rt_root),
    .sb_out    (rt_sb)
  );

  // Stage 4: mirror term.
  logic                 s4_valid;
  logic [ETERM_W-1:0]   s4_eterm;
  logic [PROD_W-1:0]    xi_prod;
  logic signed [DW-1:0] s4_z;
  logic [NW-1:0]        s4_num_x, s4_num_y;
  logic                 s4_neg_x, s4_neg_y;

  assign xi_prod = PROD_W'(mirror_xi) * PROD_W'(rt_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_eterm <= ETERM_W'(xi_prod >> FRAC_BITS);
      {s4_z, s4_num_x, s4_num_y, s4_neg_x, s4_neg_y} <= rt_sb;
    end
  end

  // Stage 5: denominator.
  logic                     s5_valid;
  logic signed [SDEN_W-1:0] s5_den;
  logic [NW-1:0]            s5_num_x, s5_num_y;
  logic                     s5_neg_x, s5_neg_y;
  logic                     s5_invalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_den   <= $signed({{(SDEN_W-DW){s4_z[DW-1]}}, s4_z})
                + $signed({{(SDEN_W-ETERM_W){1'b0}}, s4_eterm});
      s5_num_x <= s4_num_x;
      s5_num_y <= s4_num_y;
      s5_neg_x <= s4_neg_x;
      s5_neg_y <= s4_neg_y;
    end
  end

  assign s5_invalid = s5_den[SDEN_W-1] || (s5_den == '0);

  // Two divider lanes share the denominator.
  logic           du_valid, dv_valid;
  ocp_pkg::quot_t du_res, dv_res;
  logic [1:0]     du_sb;
  logic           dv_sb;

  ocp_div #(
    .DEN_W (DEN_W),
    .SB_W  (2)
  ) u_div_u (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num       (s5_num_x),
    .den       (s5_den[DEN_W-1:0]),
    .sb_in     ({s5_invalid, s5_neg_x}),
    .out_valid (du_valid),
    .res       (du_res),
    .sb_out    (du_sb)
  );

  ocp_div #(
    .DEN_W (DEN_W),
    .SB_W  (1)
  ) u_div_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num       (s5_num_y),
    .den       (s5_den[DEN_W-1:0]),
    .sb_in     (s5_neg_y),
    .out_valid (dv_valid),
    .res       (dv_res),
    .sb_out    (dv_sb)
  );

  // Stage 6: apply sign and add the principal point.
  logic                    s6_valid;
  logic signed [SUM_W-1:0] s6_sum_u, s6_sum_v;
  logic                    s6_big_u, s6_big_v;
  logic                    s6_neg_u, s6_neg_v;
  logic                    s6_invalid;
  logic signed [SQ_W-1:0]  sq_u, sq_v;

  assign sq_u = du_sb[0] ? -$signed({1'b0, du_res.quo}) : $signed({1'b0, du_res.quo});
  assign sq_v = dv_sb    ? -$signed({1'b0, dv_res.quo}) : $signed({1'b0, dv_res.quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= du_valid && dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sum_u   <= $signed({sq_u[SQ_W-1], sq_u})
                  + $signed({{(SUM_W-DW){center_x[DW-1]}}, center_x});
      s6_sum_v   <= $signed({sq_v[SQ_W-1], sq_v})
                  + $signed({{(SUM_W-DW){center_y[DW-1]}}, center_y});
      s6_big_u   <= du_res.big;
      s6_big_v   <= dv_res.big;
      s6_neg_u   <= du_sb[0];
      s6_neg_v   <= dv_sb;
      s6_invalid <= du_sb[1];
    end
  end

  // Stage 7: saturation. An oversized quotient clips toward its sign; an invalid projection gives zeros.
  logic          hi_u, lo_u, hi_v, lo_v;
  logic          s7_valid;
  logic [DW-1:0] s7_u, s7_v;
  logic          s7_invalid, s7_sat;

  assign hi_u = s6_big_u ? !s6_neg_u : (s6_sum_u > OUT_MAX);
  assign lo_u = s6_big_u ?  s6_neg_u : (s6_sum_u < OUT_MIN);
  assign hi_v = s6_big_v ? !s6_neg_v : (s6_sum_v > OUT_MAX);
  assign lo_v = s6_big_v ?  s6_neg_v : (s6_sum_v < OUT_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s6_invalid) begin
        s7_u <= '0;
        s7_v <= '0;
      end else begin
        s7_u <= hi_u ? OUT_MAX[DW-1:0] : (lo_u ? OUT_MIN[DW-1:0] : s6_sum_u[DW-1:0]);
        s7_v <= hi_v ? OUT_MAX[DW-1:0] : (lo_v ? OUT_MIN[DW-1:0] : s6_sum_v[DW-1:0]);
      end
      s7_invalid <= s6_invalid;
      s7_sat     <= !s6_invalid && (hi_u || lo_u || hi_v || lo_v);
    end
  end

  // Output register with a one-entry skid buffer.
  logic          out_valid;
  logic [DW-1:0] out_u, out_v;
  logic          out_invalid, out_sat;
  logic [DW-1:0] skid_u, skid_v;
  logic          skid_invalid, skid_sat;
  logic          take_s7;

  assign take_s7 = s7_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pixel.ready) begin
      if (take_s7) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take_s7;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !pixel.ready) begin
      if (take_s7) begin
        skid_u       <= s7_u;
        skid_v       <= s7_v;
        skid_invalid <= s7_invalid;
        skid_sat     <= s7_sat;
      end
    end else if (skid_valid) begin
      out_u       <= skid_u;
      out_v       <= skid_v;
      out_invalid <= skid_invalid;
      out_sat     <= skid_sat;
    end else begin
      out_u       <= s7_u;
      out_v       <= s7_v;
      out_invalid <= s7_invalid;
      out_sat     <= s7_sat;
    end
  end

  assign pixel.valid     = out_valid;
  assign pixel.pixel_u   = out_u;
  assign pixel.pixel_v   = out_v;
  assign pixel.invalid   = out_invalid;
  assign pixel.saturated = out_sat;

endmodule

// ----- sv/ocp_checker.sv -----
// Port-level checks of the projection block, attached to the top level by bind.
// Depends on ocp_pkg for the field widths.
module ocp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ocp_pkg::DATA_W-1:0] out_u,
  input logic signed [ocp_pkg::DATA_W-1:0] out_v,
  input logic                              out_invalid,
  input logic                              out_sat
);

  localparam logic [ocp_pkg::DATA_W-1:0] S_MAX = {1'b0, {(ocp_pkg::DATA_W-1){1'b1}}};
  localparam logic [ocp_pkg::DATA_W-1:0] S_MIN = {1'b1, {(ocp_pkg::DATA_W-1){1'b0}}};

  // No request is valid in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel request right after reset");

  // A rejected projection carries zeros and no clip flag.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_invalid) |-> (out_u == '0 && out_v == '0 && !out_sat))
    else $error("invalid pixel with nonzero payload");

  // A clip flag means at least one coordinate sits at a range limit.
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      (out_u == S_MAX || out_u == S_MIN || out_v == S_MAX || out_v == S_MIN))
    else $error("saturated flag without a clipped coordinate");

  // A stalled request holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_u) && $stable(out_v) && $stable(out_invalid)
       && $stable(out_sat)))
    else $error("stalled pixel request changed");

endmodule

bind omni_camera_projection ocp_checker u_ocp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pixel.valid),
  .out_ready   (pixel.ready),
  .out_u       (pixel.pixel_u),
  .out_v       (pixel.pixel_v),
  .out_invalid (pixel.invalid),
  .out_sat     (pixel.saturated)
);
